>>> hdl/kvlp_pkg.sv
// ---------------------------------------------------------------------------
// kvlp_pkg
// Shared types and constants for the key/value line parser.
// ---------------------------------------------------------------------------
`default_nettype none

package kvlp_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [1:0] CLS_DROP  = 2'd0;
	localparam logic [1:0] CLS_NAME  = 2'd1;
	localparam logic [1:0] CLS_VALUE = 2'd2;
	localparam logic [1:0] CLS_EOL   = 2'd3;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [3:0] DIGITS_MAX  = 4'd10;
	localparam logic [3:0] DIGITS_SAT  = 4'd11;

	// classified request passed from front to back
	typedef struct packed {
		logic [1:0] cls;
		logic [7:0] chr;
		logic       dis;
	} kvlp_req_t;

	function automatic logic is_blank(input logic [7:0] c);
		return c inside {CH_SPACE, CH_TAB};
	endfunction

endpackage

`default_nettype wire

>>> hdl/kvlp_front.sv
// ---------------------------------------------------------------------------
// kvlp_front
// Line scanner: tracks the parse phase and tags each character.
// ---------------------------------------------------------------------------
`default_nettype none

module kvlp_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire logic              kind,
	input  wire logic [7:0]        char_in,
	output kvlp_pkg::kvlp_req_t    req
);
	import kvlp_pkg::*;

	typedef enum logic [5:0] {
		PH_LEAD   = 6'b000001,
		PH_NAME   = 6'b000010,
		PH_BLANK1 = 6'b000100,
		PH_EQ     = 6'b001000,
		PH_BLANK2 = 6'b010000,
		PH_VALUE  = 6'b100000
	} phase_t;

	phase_t     phase_q, phase_nxt;
	logic       seen_q;
	logic       comment_q;
	logic       comment_set;
	logic [1:0] cls;
	logic       blank;
	logic       eq;

	assign blank = is_blank(char_in);
	assign eq    = (char_in == CH_EQ);

	always_comb begin
		phase_nxt   = phase_q;
		cls         = CLS_DROP;
		comment_set = 1'b0;
		case (phase_q)
			PH_LEAD: begin
				if (blank) begin
					cls = CLS_DROP;
				end else if (char_in == CH_HASH) begin
					comment_set = 1'b1;
					phase_nxt   = PH_NAME;
				end else if (eq) begin
					phase_nxt = PH_EQ;
				end else begin
					cls       = CLS_NAME;
					phase_nxt = PH_NAME;
				end
			end
			PH_NAME: begin
				if (eq) begin
					phase_nxt = PH_EQ;
				end else if (blank) begin
					phase_nxt = PH_BLANK1;
				end else begin
					cls = CLS_NAME;
				end
			end
			PH_BLANK1: begin
				if (eq) begin
					phase_nxt = PH_EQ;
				end else if (!blank) begin
					cls       = CLS_VALUE;
					phase_nxt = PH_VALUE;
				end
			end
			PH_EQ: begin
				if (blank) begin
					phase_nxt = PH_BLANK2;
				end else if (!eq) begin
					cls       = CLS_VALUE;
					phase_nxt = PH_VALUE;
				end
			end
			PH_BLANK2: begin
				if (!blank) begin
					cls       = CLS_VALUE;
					phase_nxt = PH_VALUE;
				end
			end
			PH_VALUE: begin
				cls = CLS_VALUE;
			end
			default: begin
				cls       = CLS_VALUE;
				phase_nxt = PH_VALUE;
			end
		endcase
	end

	always_comb begin
		if (kind) begin
			req.cls = CLS_EOL;
			req.chr = char_in;
			req.dis = !seen_q || comment_q;
		end else begin
			req.cls = cls;
			req.chr = char_in;
			req.dis = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LEAD;
			seen_q    <= 1'b0;
			comment_q <= 1'b0;
		end else if (take) begin
			if (kind) begin
				phase_q   <= PH_LEAD;
				seen_q    <= 1'b0;
				comment_q <= 1'b0;
			end else begin
				phase_q <= phase_nxt;
				seen_q  <= 1'b1;
				if (comment_set) begin
					comment_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/kvlp_queue.sv
// ---------------------------------------------------------------------------
// kvlp_queue
// Small FIFO of classified requests between scanner and evaluator.
// ---------------------------------------------------------------------------
`default_nettype none

module kvlp_queue #(
	parameter int DEPTH = kvlp_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	output logic                   push_stall,
	input  wire kvlp_pkg::kvlp_req_t push_req,
	output logic                   pop_valid,
	input  wire logic              pop_stall,
	output kvlp_pkg::kvlp_req_t    pop_req
);
	import kvlp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	kvlp_req_t     mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push, pop;

	assign push_stall = (count_q == FULL);
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;
	assign pop_req    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/kvlp_back.sv
// ---------------------------------------------------------------------------
// kvlp_back
// Value evaluator: accumulates decimal digits and registers each result.
// ---------------------------------------------------------------------------
`default_nettype none

module kvlp_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire kvlp_pkg::kvlp_req_t req,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             char_class,
	output logic [7:0]             char_out,
	output logic                   disabled,
	output logic                   int_valid,
	output logic [31:0]            int_value
);
	import kvlp_pkg::*;

	logic [31:0] acc_q;
	logic [3:0]  ndig_q;
	logic        bad_q;
	logic        out_valid_q;
	logic        take;
	logic        digit;
	logic [3:0]  dval;
	logic [7:0]  doff;
	logic [31:0] acc_nxt;
	logic        ok;

	assign req_stall = out_valid_q && out_stall;
	assign take      = req_valid && !req_stall;
	assign out_valid = out_valid_q;

	assign digit   = req.chr inside {[CH_ZERO:CH_NINE]};
	assign doff    = req.chr - CH_ZERO;
	assign dval    = doff[3:0];
	// acc * 10 + d as two shifted adds
	assign acc_nxt = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + {28'd0, dval};
	assign ok      = (ndig_q != 4'd0) && (ndig_q <= DIGITS_MAX) && !bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			acc_q       <= '0;
			ndig_q      <= '0;
			bad_q       <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				if (req.cls == CLS_EOL) begin
					acc_q  <= '0;
					ndig_q <= '0;
					bad_q  <= 1'b0;
				end else if (req.cls == CLS_VALUE) begin
					if (ndig_q < DIGITS_SAT) begin
						ndig_q <= ndig_q + 1'b1;
					end
					if (digit) begin
						acc_q <= acc_nxt;
					end else begin
						bad_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			char_class <= req.cls;
			case (req.cls)
				CLS_NAME, CLS_VALUE: begin
					char_out  <= req.chr;
					disabled  <= 1'b0;
					int_valid <= 1'b0;
					int_value <= '0;
				end
				CLS_EOL: begin
					char_out  <= '0;
					disabled  <= req.dis;
					int_valid <= ok;
					int_value <= ok ? acc_q : '0;
				end
				default: begin
					char_out  <= '0;
					disabled  <= 1'b0;
					int_valid <= 1'b0;
					int_value <= '0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hdl/key_value_line_parser_unit.sv
// Path: an accepted request is queued, then the evaluator registers its result onto out_valid.
// Throughput: one request per cycle while in_stall and out_stall are both low.
// The request queue (QUEUE_DEPTH entries) lets the scanner keep accepting during output stalls.
// Reset: arst_n clears phase, line flags, accumulator, queue pointers and output valid.
// No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
// key_value_line_parser_unit
// Parses "name = value" text lines one character per request, reports each
// character's class and, at end of line, a summary with the decimal value.
// ---------------------------------------------------------------------------
`default_nettype none

module key_value_line_parser_unit #(
	parameter int QDEPTH = kvlp_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [7:0]  char_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       char_class,
	output logic [7:0]       char_out,
	output logic             disabled,
	output logic             int_valid,
	output logic [31:0]      int_value
);
	import kvlp_pkg::*;

	kvlp_req_t front_req;
	kvlp_req_t back_req;
	logic      q_full;
	logic      q_valid;
	logic      q_stall;
	logic      take;

	assign in_stall = q_full;
	assign take     = in_valid && !q_full;

	kvlp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.kind    (kind),
		.char_in (char_in),
		.req     (front_req)
	);

	kvlp_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_stall (q_full),
		.push_req   (front_req),
		.pop_valid  (q_valid),
		.pop_stall  (q_stall),
		.pop_req    (back_req)
	);

	kvlp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (q_valid),
		.req_stall  (q_stall),
		.req        (back_req),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.char_class (char_class),
		.char_out   (char_out),
		.disabled   (disabled),
		.int_valid  (int_valid),
		.int_value  (int_value)
	);

endmodule

`default_nettype wire
